// File: design/jrs_pkg.sv
// Shared types, constants and the CRC-32 byte update for the journal record scanner.
`default_nettype none

package jrs_pkg;

    localparam int HEADER_BYTES   = 8;
    localparam int OFFSET_BITS    = 48;
    localparam int FIELD_BITS     = 32;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 32;
    localparam int VERSION_BITS   = 16;
    localparam int OUT_TDATA_BITS = 64;
    localparam int OUT_DEPTH      = 4;
    localparam int OUT_PTR_BITS   = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_BITS   = $clog2(OUT_DEPTH + 1);
    localparam int MAGIC_BYTES    = 4;

    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
    localparam logic [31:0] MAX_LEN_RST  = 32'h0100_0000;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MAGIC   = 2'd0,
        CFG_VERSION = 2'd1,
        CFG_MAX_LEN = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_SUMMARY = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        HDR_OK          = 2'd0,
        HDR_SHORT       = 2'd1,
        HDR_BAD_MAGIC   = 2'd2,
        HDR_BAD_VERSION = 2'd3
    } t_hdr_status;

    typedef struct packed {
        logic       end_of_data;
        logic       byte_present;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        t_kind                  result_kind;
        logic [7:0]             payload_byte;
        logic                   record_end;
        logic                   record_good;
        t_hdr_status            header_status;
        logic                   tail_discarded;
        logic [OFFSET_BITS-1:0] valid_bytes;
        logic                   last_of_run;
    } t_result;

    // Up to two results per input item, first one delivered first.
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: design/jrs_in_reg.sv
// Input register stage: holds one accepted item until the scanner takes it.
`default_nettype none

module jrs_in_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire jrs_pkg::t_in_item i_item,
    input  wire logic              i_space_ok,
    output logic                   o_take,
    output jrs_pkg::t_in_item      o_item
);

    logic              r_valid;
    jrs_pkg::t_in_item r_item;

    assign o_take        = r_valid && i_space_ok;
    assign s_axis_tready = !r_valid || i_space_ok;
    assign o_item        = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// File: design/jrs_scan.sv
// Scanner core: header check, record deframing, CRC check and end-of-data summary.
`default_nettype none

module jrs_scan (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [jrs_pkg::CFG_IDX_BITS-1:0]    i_cfg_addr,
    input  wire logic [jrs_pkg::CFG_DATA_BITS-1:0]   i_cfg_wdata,
    input  wire logic                                i_take,
    input  wire jrs_pkg::t_in_item                   i_item,
    output jrs_pkg::t_push                           o_push
);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_RECHDR  = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    localparam int FB = jrs_pkg::FIELD_BITS;
    localparam int OB = jrs_pkg::OFFSET_BITS;

    logic [31:0]                          r_magic_word;
    logic [jrs_pkg::VERSION_BITS-1:0]     r_format_version;
    logic [31:0]                          r_max_len;

    t_phase                r_phase, n_phase;
    logic [OB-1:0]         r_byte_offset, n_byte_offset;
    logic [FB-1:0]         r_field_index, n_field_index;
    logic [31:0]           r_len, n_len;
    logic [31:0]           r_chk, n_chk;
    logic [31:0]           r_crc, n_crc;
    logic [OB-1:0]         r_good_offset, n_good_offset;
    jrs_pkg::t_hdr_status  r_header_result, n_header_result;
    logic                  r_stopped, n_stopped;
    logic                  r_magic_bad, n_magic_bad;
    logic                  r_version_bad, n_version_bad;

    logic [FB-1:0]    fi_inc;
    logic [7:0]       b;
    logic [31:0]      crc_next;
    logic             good;
    logic             tail;
    logic             byte_res_v;
    jrs_pkg::t_result byte_res;
    jrs_pkg::t_result sum_res;

    always_comb begin
        n_phase         = r_phase;
        n_byte_offset   = r_byte_offset;
        n_field_index   = r_field_index;
        n_len           = r_len;
        n_chk           = r_chk;
        n_crc           = r_crc;
        n_good_offset   = r_good_offset;
        n_header_result = r_header_result;
        n_stopped       = r_stopped;
        n_magic_bad     = r_magic_bad;
        n_version_bad   = r_version_bad;
        fi_inc          = r_field_index + 1'b1;
        b               = i_item.data_byte;
        crc_next        = jrs_pkg::crc_byte(r_crc, b);
        good            = 1'b0;
        tail            = 1'b0;
        byte_res_v      = 1'b0;
        byte_res        = '0;
        sum_res         = '0;
        o_push          = '0;

        if (i_take && i_item.byte_present && !r_stopped) begin
            n_byte_offset = r_byte_offset + 1'b1;
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_field_index < FB'(jrs_pkg::MAGIC_BYTES)
                        && b != r_magic_word[{r_field_index[1:0], 3'b000} +: 8]) begin
                        n_magic_bad = 1'b1;
                    end
                    if (r_field_index == FB'(4) && b != r_format_version[7:0]) begin
                        n_version_bad = 1'b1;
                    end
                    if (r_field_index == FB'(5) && b != r_format_version[15:8]) begin
                        n_version_bad = 1'b1;
                    end
                    if (r_field_index == FB'(jrs_pkg::HEADER_BYTES - 1)) begin
                        n_header_result = n_magic_bad   ? jrs_pkg::HDR_BAD_MAGIC :
                                          n_version_bad ? jrs_pkg::HDR_BAD_VERSION :
                                                          jrs_pkg::HDR_OK;
                        n_phase       = PH_RECHDR;
                        n_field_index = '0;
                    end else begin
                        n_field_index = fi_inc;
                    end
                end
                PH_RECHDR: begin
                    if (!r_field_index[2]) begin
                        n_len[{r_field_index[1:0], 3'b000} +: 8] = b;
                    end else begin
                        n_chk[{r_field_index[1:0], 3'b000} +: 8] = b;
                    end
                    if (r_field_index == FB'(7)) begin
                        n_field_index = '0;
                        if (n_len > r_max_len) begin
                            n_stopped = 1'b1;
                        end else if (n_len == 32'd0) begin
                            good                 = (n_chk == 32'd0);
                            byte_res_v           = 1'b1;
                            byte_res.result_kind = jrs_pkg::KIND_EMPTY;
                            byte_res.record_end  = 1'b1;
                            byte_res.record_good = good;
                            if (good) begin
                                n_good_offset = n_byte_offset;
                            end else begin
                                n_stopped = 1'b1;
                            end
                        end else begin
                            n_phase = PH_PAYLOAD;
                            n_crc   = jrs_pkg::CRC_INIT;
                        end
                    end else begin
                        n_field_index = fi_inc;
                    end
                end
                PH_PAYLOAD: begin
                    n_crc                 = crc_next;
                    byte_res_v            = 1'b1;
                    byte_res.result_kind  = jrs_pkg::KIND_PAYLOAD;
                    byte_res.payload_byte = b;
                    if (fi_inc == r_len) begin
                        good                 = ((~crc_next) == r_chk);
                        byte_res.record_end  = 1'b1;
                        byte_res.record_good = good;
                        if (good) begin
                            n_good_offset = n_byte_offset;
                        end else begin
                            n_stopped = 1'b1;
                        end
                        n_phase       = PH_RECHDR;
                        n_field_index = '0;
                    end else begin
                        n_field_index = fi_inc;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end

        if (i_take && i_item.end_of_data) begin
            tail = n_stopped || n_phase == PH_PAYLOAD
                || (n_phase == PH_RECHDR && n_field_index != '0);
            sum_res.result_kind    = jrs_pkg::KIND_SUMMARY;
            sum_res.header_status  = n_header_result;
            sum_res.tail_discarded = tail;
            sum_res.valid_bytes    = n_good_offset;
            sum_res.last_of_run    = 1'b1;
            // new journal starts with the next byte
            n_phase         = PH_HEADER;
            n_byte_offset   = '0;
            n_field_index   = '0;
            n_len           = '0;
            n_chk           = '0;
            n_crc           = jrs_pkg::CRC_INIT;
            n_good_offset   = '0;
            n_header_result = jrs_pkg::HDR_SHORT;
            n_stopped       = 1'b0;
            n_magic_bad     = 1'b0;
            n_version_bad   = 1'b0;
            if (byte_res_v) begin
                o_push.count  = 2'd2;
                o_push.first  = byte_res;
                o_push.second = sum_res;
            end else begin
                o_push.count = 2'd1;
                o_push.first = sum_res;
            end
        end else if (byte_res_v) begin
            byte_res.last_of_run = 1'b1;
            o_push.count         = 2'd1;
            o_push.first         = byte_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_word     <= '0;
            r_format_version <= '0;
            r_max_len        <= jrs_pkg::MAX_LEN_RST;
            r_phase          <= PH_HEADER;
            r_byte_offset    <= '0;
            r_field_index    <= '0;
            r_crc            <= jrs_pkg::CRC_INIT;
            r_good_offset    <= '0;
            r_header_result  <= jrs_pkg::HDR_SHORT;
            r_stopped        <= 1'b0;
            r_magic_bad      <= 1'b0;
            r_version_bad    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    jrs_pkg::CFG_MAGIC:   r_magic_word <= i_cfg_wdata;
                    jrs_pkg::CFG_VERSION: begin
                        r_format_version <= i_cfg_wdata[jrs_pkg::VERSION_BITS-1:0];
                    end
                    jrs_pkg::CFG_MAX_LEN: r_max_len <= i_cfg_wdata;
                    default: begin
                        r_max_len <= r_max_len;
                    end
                endcase
            end
            r_phase         <= n_phase;
            r_byte_offset   <= n_byte_offset;
            r_field_index   <= n_field_index;
            r_crc           <= n_crc;
            r_good_offset   <= n_good_offset;
            r_header_result <= n_header_result;
            r_stopped       <= n_stopped;
            r_magic_bad     <= n_magic_bad;
            r_version_bad   <= n_version_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len;
        r_chk <= n_chk;
    end

    a_header_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && r_phase == PH_HEADER && !i_item.end_of_data) |-> (o_push.count == 2'd0))
        else $error("header byte produced a result");

    a_stopped_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && r_stopped && !i_item.end_of_data) |-> (o_push.count == 2'd0))
        else $error("result after scan stop");

    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_item.end_of_data) |->
            ((o_push.count == 2'd1 && o_push.first.result_kind == jrs_pkg::KIND_SUMMARY)
          || (o_push.count == 2'd2 && o_push.second.result_kind == jrs_pkg::KIND_SUMMARY)))
        else $error("end marker without trailing summary");

    a_clear_after_eod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_item.end_of_data) |=>
            (r_phase == PH_HEADER && r_byte_offset == '0 && !r_stopped))
        else $error("scan state not cleared after summary");

endmodule

`default_nettype wire

// File: design/jrs_out_queue.sv
// Four-entry result queue: takes up to two results per cycle, delivers one.
`default_nettype none

module jrs_out_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire jrs_pkg::t_push i_push,
    output logic                o_space_ok,
    output logic                o_valid,
    input  wire logic           i_ready,
    output jrs_pkg::t_result    o_result
);

    localparam int PB = jrs_pkg::OUT_PTR_BITS;
    localparam int CB = jrs_pkg::OUT_CNT_BITS;

    jrs_pkg::t_result r_mem [jrs_pkg::OUT_DEPTH];
    logic [PB-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CB-1:0]    r_count, n_count;
    logic             pop;
    logic [PB-1:0]    wr_ptr_1;

    assign o_space_ok = (r_count <= CB'(jrs_pkg::OUT_DEPTH - 2));
    assign o_valid    = (r_count != '0);
    assign o_result   = r_mem[r_rd_ptr];
    assign pop        = o_valid && i_ready;
    assign wr_ptr_1   = r_wr_ptr + 1'b1;

    always_comb begin
        n_count = r_count + CB'(i_push.count) - CB'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PB'(i_push.count);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_1] <= i_push.second;
        end
    end

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> (r_count <= CB'(jrs_pkg::OUT_DEPTH - 2)))
        else $error("push into a full result queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> (r_count <= CB'(jrs_pkg::OUT_DEPTH)))
        else $error("result queue count overflow");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> (PB'(r_wr_ptr - r_rd_ptr) == r_count[PB-1:0]))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// File: design/journal_record_scanner_core.sv
// Top level of the journal record scanner: byte stream in, deframed payload and verdicts out.
`default_nettype none

// Takes one journal byte per cycle while the output queue has room. An item
// is registered on entry and handled by the scanner once the output queue
// has room, and the scanner writes its results into the queue registers,
// from which the first result is presented on the output. Each item yields
// zero, one or two results; two arise only when a byte and the end marker
// come together, and a four-entry output queue absorbs them so input stalls
// only while that queue holds more than two results. CRC-32 is checked one
// byte per cycle while input is not stalled. Configuration registers must be
// written by the user through the plain write port only while the stream is
// idle; the block does not enforce it. They take effect for the next item.
module journal_record_scanner_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [jrs_pkg::CFG_IDX_BITS-1:0]    i_cfg_addr,
    input  wire logic [jrs_pkg::CFG_DATA_BITS-1:0]   i_cfg_wdata,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [7:0]                          s_axis_tdata,  // data_byte
    input  wire logic                                s_axis_tuser,  // byte_present
    input  wire logic                                s_axis_tlast,  // end_of_data
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // payload_byte[7:0], record_end[8], record_good[9], header_status[11:10],
    // tail_discarded[12], valid_bytes[60:13], zero fill[63:61]
    output logic [jrs_pkg::OUT_TDATA_BITS-1:0]       m_axis_tdata,
    output logic [1:0]                               m_axis_tuser,  // result_kind
    output logic                                     m_axis_tlast   // last_of_run
);

    jrs_pkg::t_in_item in_item;
    jrs_pkg::t_in_item held_item;
    jrs_pkg::t_push    push;
    jrs_pkg::t_result  res;
    logic              take;
    logic              space_ok;

    assign in_item.data_byte    = s_axis_tdata;
    assign in_item.byte_present = s_axis_tuser;
    assign in_item.end_of_data  = s_axis_tlast;

    jrs_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_item        (in_item),
        .i_space_ok    (space_ok),
        .o_take        (take),
        .o_item        (held_item)
    );

    jrs_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_take      (take),
        .i_item      (held_item),
        .o_push      (push)
    );

    jrs_out_queue u_out_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_space_ok (space_ok),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (res)
    );

    assign m_axis_tdata = {3'b000, res.valid_bytes, res.tail_discarded, res.header_status,
                           res.record_good, res.record_end, res.payload_byte};
    assign m_axis_tuser = res.result_kind;
    assign m_axis_tlast = res.last_of_run;

endmodule

`default_nettype wire

// File: tb/sv/journal_record_scanner_core_tb.sv
// Self-checking testbench for journal_record_scanner_core: directed table, random journals.
`timescale 1ns / 1ps

module journal_record_scanner_core_tb;
    import jrs_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int PRESSURE_HOLD = 200;
    localparam int PHASE_ITEMS   = 55;
    localparam int NUM_PHASES    = 6;

    typedef enum logic [1:0] {SCAN_HEADER, SCAN_REC_HEAD, SCAN_PAYLOAD} t_scan_phase;

    typedef struct {
        t_in_item item;
        bit       typed;
        t_result  want;
    } t_dir_row;

    logic                      i_clk;
    logic                      i_rst_n       = 1'b0;
    logic                      i_cfg_we      = 1'b0;
    logic [CFG_IDX_BITS-1:0]   i_cfg_addr    = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_wdata   = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata  = 8'd0;  // data_byte
    logic                      s_axis_tuser  = 1'b0;  // byte_present
    logic                      s_axis_tlast  = 1'b0;  // end_of_data
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // payload_byte, record_end, record_good, header_status, tail_discarded, valid_bytes
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
    logic [1:0]                m_axis_tuser;          // result_kind
    logic                      m_axis_tlast;          // last_of_run

    journal_record_scanner_core u_dut (.*);

    // scanner state as the testbench sees it
    t_scan_phase              scan_phase;
    logic [OFFSET_BITS-1:0]   byte_pos, good_pos;
    logic [31:0]              field_pos, rec_len, rec_sum, crc_acc;
    t_hdr_status              hdr_result;
    logic                     halted, magic_mismatch, version_mismatch;
    logic [31:0]              cfg_magic   = 32'd0;
    logic [15:0]              cfg_version = 16'd0;
    logic [31:0]              cfg_max_len = MAX_LEN_RST;

    t_result    pending_results[$];
    t_in_item   journal_items[$];
    t_dir_row   dir_table[$];
    int         fail_count     = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    bit         pressure_req   = 1'b0;
    int         quiet_cycles   = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] c;
        c = acc;
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ ((c[0] ^ b[k]) ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    function automatic t_in_item as_byte(input logic [7:0] b);
        return '{end_of_data: 1'b0, byte_present: 1'b1, data_byte: b};
    endfunction

    function automatic string fmt_result(input t_result r);
        return $sformatf("kind=%0d byte=%h end=%b good=%b hdr=%0d tail=%b valid=%0d last=%b",
                         r.result_kind, r.payload_byte, r.record_end, r.record_good,
                         r.header_status, r.tail_discarded, r.valid_bytes, r.last_of_run);
    endfunction

    task automatic clear_scan();
        scan_phase       = SCAN_HEADER;
        byte_pos         = '0;
        field_pos        = 32'd0;
        rec_len          = 32'd0;
        rec_sum          = 32'd0;
        crc_acc          = CRC_INIT;
        good_pos         = '0;
        hdr_result       = HDR_SHORT;
        halted           = 1'b0;
        magic_mismatch   = 1'b0;
        version_mismatch = 1'b0;
    endtask

    // Works out the results one accepted item causes and queues them.
    task automatic deframe_item(input t_in_item it);
        t_result     res[2];
        int          n;
        logic [7:0]  b;
        logic [31:0] fi;
        logic        good, tail;
        n = 0;
        res[0] = '0;
        res[1] = '0;
        b = it.data_byte;
        if (it.byte_present && !halted) begin
            fi = field_pos;
            byte_pos = byte_pos + 1'b1;
            case (scan_phase)
                SCAN_HEADER: begin
                    if (fi < 4 && b != cfg_magic[8*fi[1:0] +: 8]) magic_mismatch = 1'b1;
                    if (fi == 4 && b != cfg_version[7:0]) version_mismatch = 1'b1;
                    if (fi == 5 && b != cfg_version[15:8]) version_mismatch = 1'b1;
                    field_pos = fi + 1;
                    if (field_pos >= HEADER_BYTES) begin
                        hdr_result = magic_mismatch ? HDR_BAD_MAGIC :
                                     (version_mismatch ? HDR_BAD_VERSION : HDR_OK);
                        scan_phase = SCAN_REC_HEAD;
                        field_pos  = 32'd0;
                    end
                end
                SCAN_REC_HEAD: begin
                    if (fi == 0) begin
                        rec_len = 32'd0;
                        rec_sum = 32'd0;
                    end
                    if (fi < 4) rec_len[8*fi[1:0] +: 8] = b;
                    else rec_sum[8*fi[1:0] +: 8] = b;
                    field_pos = fi + 1;
                    if (field_pos >= 8) begin
                        field_pos = 32'd0;
                        if (rec_len > cfg_max_len) begin
                            halted = 1'b1;
                        end else if (rec_len == 0) begin
                            good = (rec_sum == 32'd0);
                            res[n] = '{KIND_EMPTY, 8'd0, 1'b1, good, HDR_OK, 1'b0, '0, 1'b0};
                            n++;
                            if (good) good_pos = byte_pos;
                            else halted = 1'b1;
                        end else begin
                            scan_phase = SCAN_PAYLOAD;
                            crc_acc    = CRC_INIT;
                        end
                    end
                end
                default: begin
                    crc_acc = crc32_step(crc_acc, b);
                    field_pos = fi + 1;
                    if (field_pos >= rec_len) begin
                        good = ((crc_acc ^ CRC_INIT) == rec_sum);
                        res[n] = '{KIND_PAYLOAD, b, 1'b1, good, HDR_OK, 1'b0, '0, 1'b0};
                        n++;
                        if (good) good_pos = byte_pos;
                        else halted = 1'b1;
                        scan_phase = SCAN_REC_HEAD;
                        field_pos  = 32'd0;
                    end else begin
                        res[n] = '{KIND_PAYLOAD, b, 1'b0, 1'b0, HDR_OK, 1'b0, '0, 1'b0};
                        n++;
                    end
                end
            endcase
        end
        if (it.end_of_data) begin
            tail = halted || scan_phase == SCAN_PAYLOAD ||
                   (scan_phase == SCAN_REC_HEAD && field_pos != 0);
            res[n] = '{KIND_SUMMARY, 8'd0, 1'b0, 1'b0, hdr_result, tail, good_pos, 1'b0};
            n++;
            clear_scan();
        end
        if (n > 0) res[n-1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++) pending_results.push_back(res[i]);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input t_in_item it, input bit typed, input t_result want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it.data_byte;
        s_axis_tuser  <= it.byte_present;
        s_axis_tlast  <= it.end_of_data;
        do @(posedge i_clk); while (!s_axis_tready);
        deframe_item(it);
        if (typed) begin
            void'(pending_results.pop_back());
            pending_results.push_back(want);
        end
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_MAGIC:   cfg_magic   = val;
            CFG_VERSION: cfg_version = val[15:0];
            CFG_MAX_LEN: cfg_max_len = val;
            default: ;
        endcase
    endtask

    // One journal: mostly well formed, with corrupted, oversize and cut-off variants.
    task automatic build_journal();
        t_in_item    jr[$];
        t_in_item    last_item;
        logic [7:0]  pay[$];
        logic [31:0] len, sum;
        logic [7:0]  hb;
        int          pick, cut;
        if ($urandom_range(99) < 5) begin
            repeat ($urandom_range(1, 20)) jr.push_back(as_byte(8'($urandom)));
        end else begin
            for (int i = 0; i < HEADER_BYTES; i++) begin
                if (i < 4) hb = 8'(cfg_magic >> (8*i));
                else if (i < 6) hb = 8'(cfg_version >> (8*(i-4)));
                else hb = 8'($urandom);
                if (i < 6 && $urandom_range(99) < 3) hb ^= 8'(1 << $urandom_range(7));
                jr.push_back(as_byte(hb));
            end
            repeat ($urandom_range(0, 4)) begin
                pick = $urandom_range(99);
                pay = {};
                if (pick < 10 && cfg_max_len != 32'hFFFF_FFFF) begin
                    len = (pick < 5) ? cfg_max_len + 1 :
                          $urandom_range(32'hFFFF_FFFF, cfg_max_len + 1);
                    sum = $urandom;
                end else if (pick < 22 || cfg_max_len == 0) begin
                    len = 32'd0;
                    sum = (pick < 19) ? 32'd0 : $urandom;
                end else begin
                    len = (pick < 26) ? $urandom_range(20, 60) : $urandom_range(1, 6);
                    if (len > cfg_max_len) len = cfg_max_len;
                    sum = CRC_INIT;
                    repeat (len) begin
                        hb = 8'($urandom);
                        pay.push_back(hb);
                        sum = crc32_step(sum, hb);
                    end
                    sum = ~sum;
                    if ($urandom_range(99) < 10) sum ^= 32'(1) << $urandom_range(31);
                end
                for (int k = 0; k < 4; k++) jr.push_back(as_byte(8'(len >> (8*k))));
                for (int k = 0; k < 4; k++) jr.push_back(as_byte(8'(sum >> (8*k))));
                foreach (pay[k]) jr.push_back(as_byte(pay[k]));
            end
            if ($urandom_range(99) < 20) begin
                cut = $urandom_range(1, (jr.size() < 12) ? jr.size() : 12);
                repeat (cut) void'(jr.pop_back());
            end
        end
        if ($urandom_range(99) < 50 || jr.size() == 0) begin
            jr.push_back('{end_of_data: 1'b1, byte_present: 1'b0, data_byte: 8'($urandom)});
        end else begin
            last_item = jr.pop_back();
            last_item.end_of_data = 1'b1;
            jr.push_back(last_item);
        end
        journal_items = jr;
    endtask

    // output side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (pressure_req) begin
                pressure_req = 1'b0;
                for (int n = 0; n < PRESSURE_HOLD; n++) begin
                    m_axis_tready <= 1'b0;
                    @(negedge i_clk);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.result_kind    = t_kind'(m_axis_tuser);
            got.payload_byte   = m_axis_tdata[7:0];
            got.record_end     = m_axis_tdata[8];
            got.record_good    = m_axis_tdata[9];
            got.header_status  = t_hdr_status'(m_axis_tdata[11:10]);
            got.tail_discarded = m_axis_tdata[12];
            got.valid_bytes    = m_axis_tdata[60:13];
            got.last_of_run    = m_axis_tlast;
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) $display("unexpected result: %s", fmt_result(got));
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch at %0t\n  want %s\n  got  %s", $realtime,
                                 fmt_result(want), fmt_result(got));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        t_in_item    it;
        int          sent;
        logic [31:0] max_len;
        clear_scan();

        dir_table.push_back('{'{1'b1, 1'b0, 8'h00}, 1'b1,
                              '{KIND_SUMMARY, 8'd0, 1'b0, 1'b0, HDR_SHORT, 1'b0, '0, 1'b1}});
        dir_table.push_back('{'{1'b0, 1'b0, 8'hFF}, 1'b0, '0});
        repeat (6) dir_table.push_back('{as_byte(8'h00), 1'b0, '0});
        dir_table.push_back('{as_byte(8'hFF), 1'b0, '0});
        dir_table.push_back('{as_byte(8'h80), 1'b0, '0});
        repeat (7) dir_table.push_back('{as_byte(8'h00), 1'b0, '0});
        dir_table.push_back('{as_byte(8'h00), 1'b1,
                              '{KIND_EMPTY, 8'd0, 1'b1, 1'b1, HDR_OK, 1'b0, '0, 1'b1}});
        // one-byte record: length 1, CRC of a single zero byte
        dir_table.push_back('{as_byte(8'h01), 1'b0, '0});
        repeat (3) dir_table.push_back('{as_byte(8'h00), 1'b0, '0});
        dir_table.push_back('{as_byte(8'h8D), 1'b0, '0});
        dir_table.push_back('{as_byte(8'hEF), 1'b0, '0});
        dir_table.push_back('{as_byte(8'h02), 1'b0, '0});
        dir_table.push_back('{as_byte(8'hD2), 1'b0, '0});
        dir_table.push_back('{'{1'b1, 1'b1, 8'h00}, 1'b1,
                              '{KIND_SUMMARY, 8'd0, 1'b0, 1'b0, HDR_OK, 1'b0, 48'd25, 1'b1}});

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[r]) send_item(dir_table[r].item, dir_table[r].typed, dir_table[r].want);
        s_axis_tvalid <= 1'b0;

        for (int p = 0; p < NUM_PHASES; p++) begin
            while (pending_results.size() != 0) @(posedge i_clk);
            repeat (8) @(posedge i_clk);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            if (p == 4) pressure_req = 1'b1;
            case (p)
                0: begin
                    write_reg(CFG_MAGIC, 32'hFFFF_FFFF);
                    write_reg(CFG_VERSION, 32'hFFFF_FFFF);
                    max_len = 32'hFFFF_FFFF;
                end
                1: begin
                    write_reg(CFG_MAGIC, 32'd0);
                    write_reg(CFG_VERSION, 32'd0);
                    max_len = 32'd0;
                end
                default: begin
                    write_reg(CFG_MAGIC, $urandom);
                    write_reg(CFG_VERSION, $urandom);
                    case (p)
                        2: max_len = 32'd6;
                        3: max_len = MAX_LEN_RST;
                        4: max_len = $urandom_range(1, 12);
                        default: max_len = $urandom_range(0, 40);
                    endcase
                end
            endcase
            write_reg(CFG_MAX_LEN, max_len);
            @(negedge i_clk);
            i_cfg_we <= 1'b0;

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                build_journal();
                while (journal_items.size() != 0) begin
                    it = journal_items.pop_front();
                    if ($urandom_range(99) < 4)
                        send_item('{1'b0, 1'b0, 8'($urandom)}, 1'b0, '0);
                    send_item(it, 1'b0, '0);
                    sent++;
                end
            end
            s_axis_tvalid <= 1'b0;
        end

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            fail_count += pending_results.size();
            $display("%0d expected results never arrived", pending_results.size());
        end
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
